### rtl/core/swm_pkg.sv
// swm_pkg: shared types and fixed constants of the sliding-window maximum filter.
// No dependencies; imported by swm_ctrl and sliding_window_max.
`default_nettype none

package swm_pkg;

	// Width of the window-length register, fixed by the register map.
	localparam int CFG_BITS = 7;

	// Per-cycle control from the sequencer to the datapath.
	typedef struct packed {
		logic shift;  // request accepted: advance the cell chain
		logic load;   // move the staged result into the output register
	} swm_step_t;

endpackage : swm_pkg

`default_nettype wire

### rtl/core/sliding_window_max.sv
// sliding_window_max: streaming maximum over the last window_size samples.
// Depends on swm_pkg, swm_cell and swm_ctrl.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------
//  input    | in_valid / in_stall          | sample (signed), restart
//  output   | out_valid / out_stall        | window_max (signed)
//  config   | cfg_write, no back-pressure  | window_size
//
// One sample is taken per clock while in_stall is low. Its result, if any, is
// staged in the output-select register after the chain update, then moved by
// the cell select into the output register that drives window_max.
// in_stall rises only when a result is staged and the output register holds
// an untaken result under out_stall. Reset clears the fill count, the staging
// flags and the window register (back to one); the cells hold data only and
// need no clearing pass.
`default_nettype none

module sliding_window_max
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  signed [SAMPLE_BITS-1:0] sample,
	input  wire                          restart,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	input  wire                          cfg_write,
	input  wire  [CFG_BITS-1:0]          window_size
);

	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	swm_step_t                     step;
	logic [IDX_W-1:0]              sel_s1;
	logic signed [SAMPLE_BITS-1:0] cell_max [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] window_max_q;

	// Sequencer: window clamp, fill count, handshake and result staging.
	swm_ctrl #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.restart    (restart),
		.out_stall  (out_stall),
		.cfg_write  (cfg_write),
		.window_size(window_size),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.step       (step),
		.sel_s1     (sel_s1)
	);

	// Chain of cells: cell k holds the maximum of the newest k+1 samples.
	// Each accepted sample shifts every cell one place deeper and folds the
	// sample in, so the maximum of a window of w samples sits in cell w-1.
	// A restart needs no flush: once w samples of the new sequence are in,
	// cell w-1 covers only those, and the fill count holds results until then.
	for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] feed;

		if (k == 0) begin : g_head
			assign feed = sample;
		end else begin : g_body
			assign feed = cell_max[k-1];
		end

		swm_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk    (clk),
			.shift  (step.shift),
			.feed   (feed),
			.sample (sample),
			.max_q  (cell_max[k])
		);
	end

	// Pick the cell that matches the staged window length; the fill count
	// guarantees that cell covers the current sequence whenever a result was staged.
	always_ff @(posedge clk) begin
		if (step.load) begin
			window_max_q <= cell_max[sel_s1];
		end
	end

	assign window_max = window_max_q;

endmodule : sliding_window_max

`default_nettype wire

### rtl/core/swm_cell.sv
// swm_cell: one link of the running-maximum chain.
// Stand-alone; instantiated in a row by sliding_window_max.
`default_nettype none

module swm_cell #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire                          clk,
	input  wire                          shift,
	input  wire  signed [SAMPLE_BITS-1:0] feed,
	input  wire  signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SAMPLE_BITS-1:0] max_q
);

	// Take the larger of the neighbor's maximum and the new sample.
	always_ff @(posedge clk) begin
		if (shift) begin
			max_q <= (feed > sample) ? feed : sample;
		end
	end

endmodule : swm_cell

`default_nettype wire

### rtl/core/swm_ctrl.sv
// swm_ctrl: window register, sequence fill count, handshake and result staging.
// Depends on swm_pkg.
`default_nettype none

module swm_ctrl
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX = 64,
	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 restart,
	input  wire                 out_stall,
	input  wire                 cfg_write,
	input  wire  [CFG_BITS-1:0] window_size,
	output logic                in_stall,
	output logic                out_valid,
	output swm_step_t           step,
	output logic [IDX_W-1:0]    sel_s1
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int CW    = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

	logic [CFG_BITS-1:0] window_size_q;
	logic [CNT_W-1:0]    seen_q;
	logic                emit_s1;
	logic                out_valid_q;

	logic [CW-1:0]    cfg_ext;
	logic [CW-1:0]    win_c;
	logic [CNT_W-1:0] win;
	logic [CNT_W-1:0] win_m1;
	logic [CNT_W:0]   seen_inc;
	logic [CNT_W:0]   seen_next;
	logic             emit;
	logic             accept;
	logic             load;
	logic             s1_free;

	// Clamp the window length: zero acts as one, above the cell count as the cell count.
	always_comb begin
		cfg_ext = CW'(window_size_q);
		if (cfg_ext == '0) begin
			win_c = CW'(1);
		end else if (cfg_ext > CW'(WINDOW_MAX)) begin
			win_c = CW'(WINDOW_MAX);
		end else begin
			win_c = cfg_ext;
		end
		win    = win_c[CNT_W-1:0];
		win_m1 = win - CNT_W'(1);
	end

	// Fill count saturates at the current window length.
	always_comb begin
		seen_inc  = (restart ? '0 : {1'b0, seen_q}) + (CNT_W+1)'(1);
		seen_next = (seen_inc < {1'b0, win}) ? seen_inc : {1'b0, win};
		emit      = (seen_next == {1'b0, win});
	end

	// Hold the chain while a staged result cannot leave.
	always_comb begin
		load       = emit_s1 && (!out_valid_q || !out_stall);
		s1_free    = !emit_s1 || load;
		in_stall   = !s1_free;
		accept     = in_valid && s1_free;
		step.shift = accept;
		step.load  = load;
		out_valid  = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= CFG_BITS'(1);
		end else if (cfg_write) begin
			window_size_q <= window_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			emit_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				seen_q  <= seen_next[CNT_W-1:0];
				emit_s1 <= emit;
			end else if (load) begin
				emit_s1 <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_s1 <= win_m1[IDX_W-1:0];
		end
	end

endmodule : swm_ctrl

`default_nettype wire

### rtl/core/swm_checker.sv
// swm_checker: port-level checks of the sliding-window maximum filter.
// Bound to sliding_window_max; uses its ports only.
`default_nettype none

module swm_checker #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   in_valid,
	input wire                   in_stall,
	input wire                   restart,
	input wire                   out_valid,
	input wire                   out_stall,
	input wire [SAMPLE_BITS-1:0] window_max,
	input wire                   cfg_write,
	input wire [6:0]             window_size
);

	logic [6:0] win_q;

	// Track the window register from the write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 7'd1;
		end else if (cfg_write) begin
			win_q <= window_size;
		end
	end

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(window_max))
		else $error("stalled result changed");

	// Input back-pressure only comes from a blocked output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// The first sample of a sequence yields nothing when the window exceeds one.
	a_restart_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && restart && !cfg_write && (WINDOW_MAX > 1)
		&& (win_q > 7'd1) |=> ##1 !$rose(out_valid))
		else $error("result after first sample of a sequence");

endmodule : swm_checker

bind sliding_window_max swm_checker #(
	.WINDOW_MAX (WINDOW_MAX),
	.SAMPLE_BITS(SAMPLE_BITS)
) u_swm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.restart    (restart),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.window_max (window_max),
	.cfg_write  (cfg_write),
	.window_size(window_size)
);

`default_nettype wire

### tb/tb_sliding_window_max.sv
`timescale 1ns / 100ps
// tb_sliding_window_max: self-checking bench for the sliding-window maximum filter.
// Depends on swm_pkg and sliding_window_max; predicts every window maximum in-bench.

module tb_sliding_window_max;
	import swm_pkg::*;

	localparam int WIN_DEPTH     = 64;
	localparam int SAMPLE_W      = 16;
	localparam int SETTLE_CYCLES = 8;       // drain margin after the last request
	localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_BUDGET  = 120;

	// Shapes of generated sample runs.
	typedef enum int {
		RUN_WIDE,    // uniform over the full range
		RUN_NARROW,  // tiny range, lots of equal values
		RUN_FALL,    // descending ramp, grows the queue
		RUN_RISE,    // ascending ramp, flushes the queue
		RUN_EDGE     // only the extreme codes
	} run_shape_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       restart;
	} sample_req_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic [6:0]                 pos;
	} peak_entry_t;

	// DUT-facing signals, known from time zero.
	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic signed [SAMPLE_W-1:0]  sample = '0;
	logic                        restart = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0]  window_max;
	logic                        cfg_write = 1'b0;
	logic [CFG_BITS-1:0]         window_size = '0;

	// Stimulus and scoreboard.
	sample_req_t                 pending_reqs[$];
	logic signed [SAMPLE_W-1:0]  max_expected[$];
	sample_req_t                 req_next;
	logic signed [SAMPLE_W-1:0]  peak_next;
	logic signed [SAMPLE_W-1:0]  max_want;

	// Predictor state: monotonic queue, position counter, fill count, window register.
	peak_entry_t                 peak_q[$];
	logic [6:0]                  run_pos = '0;
	int                          run_seen = 0;
	logic [CFG_BITS-1:0]         win_len_reg = 7'd1;

	// Idling control shared with the stimulus process.
	bit                          calm = 1'b0;
	bit                          squeeze = 1'b0;
	bit                          squeeze_done = 1'b0;
	int                          hold_left = 0;

	int                          samples_taken = 0;
	int                          maxima_checked = 0;
	int                          fail_count = 0;
	int                          settings_used = 0;
	int                          cycle_count = 0;

	logic [CFG_BITS-1:0]         win_plan [0:9] = '{7'd64, 7'd127, 7'd65, 7'd2, 7'd1,
	                                                 7'd0, 7'd5, 7'd40, 7'd3, 7'd100};

	sliding_window_max #(
		.WINDOW_MAX (WIN_DEPTH),
		.SAMPLE_BITS(SAMPLE_W)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.window_max (window_max),
		.cfg_write  (cfg_write),
		.window_size(window_size)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Advance the running-maximum model by one sample. Return 1 when the window
	// is full and a maximum is due; the maximum comes back through peak.
	function automatic bit predict_max(input logic signed [SAMPLE_W-1:0] x, input logic fresh,
			output logic signed [SAMPLE_W-1:0] peak);
		peak_entry_t         e;
		logic [CFG_BITS-1:0] span;
		logic [6:0]          age;
		// Clamp the register: zero means one, anything past the depth means the depth.
		if (win_len_reg == 0)
			span = 7'd1;
		else if (win_len_reg > WIN_DEPTH)
			span = CFG_BITS'(WIN_DEPTH);
		else
			span = win_len_reg;
		// Restart wipes the queue before the sample is taken.
		if (fresh) begin
			peak_q.delete();
			run_pos = '0;
			run_seen = 0;
		end
		// Retire entries that aged out; the 7-bit subtraction wraps like the position counter.
		while (peak_q.size() > 0) begin
			age = run_pos - peak_q[0].pos;
			if (age < span)
				break;
			peak_q.delete(0);
		end
		// Drop back entries not greater than the new sample; equal values yield to the newer one.
		while (peak_q.size() > 0 && peak_q[$].value <= x)
			peak_q.delete(peak_q.size() - 1);
		if (peak_q.size() >= WIN_DEPTH)
			peak_q.delete(0);
		e.value = x;
		e.pos = run_pos;
		peak_q.insert(peak_q.size(), e);
		run_pos = run_pos + 7'd1;
		if (run_seen < span)
			run_seen++;
		else
			run_seen = int'(span);
		peak = peak_q[0].value;
		return run_seen >= span;
	endfunction

	// Driver: on acceptance, predict; then offer the next request or idle.
	// Hold valid and payload steady while stalled.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			samples_taken++;
			if (predict_max(sample, restart, peak_next))
				max_expected.insert(max_expected.size(), peak_next);
		end
		if (!in_valid || !in_stall) begin
			if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 6)) begin
				req_next = pending_reqs[0];
				pending_reqs.delete(0);
				in_valid <= 1'b1;
				sample   <= req_next.sample;
				restart  <= req_next.restart;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each taken maximum against the oldest prediction, then
	// pick the stall for the next cycle. A squeeze request turns into one long
	// hold-off so the block backs up and stalls its input.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (max_expected.size() == 0) begin
				$error("window_max: no maximum expected, got %0d", window_max);
				fail_count++;
			end else begin
				max_want = max_expected[0];
				max_expected.delete(0);
				maxima_checked++;
				if (window_max !== max_want) begin
					$error("window_max: expected %0d, actual %0d", max_want, window_max);
					fail_count++;
				end
			end
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (squeeze && !squeeze_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			squeeze_done <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 6);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("run exceeded %0d cycles", CYCLE_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_req(input logic signed [SAMPLE_W-1:0] v, input logic r);
		sample_req_t q;
		q.sample = v;
		q.restart = r;
		pending_reqs.insert(pending_reqs.size(), q);
	endtask

	// Wait until every request is in and every maximum is out, then let
	// requests that produce no maximum drain from the pipeline.
	task automatic settle();
		while (pending_reqs.size() != 0 || in_valid || max_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the window register while the block is idle.
	task automatic write_window(input logic [CFG_BITS-1:0] v);
		settle();
		@(posedge clk);
		cfg_write   <= 1'b1;
		window_size <= v;
		@(posedge clk);
		cfg_write   <= 1'b0;
		win_len_reg = v;
		settings_used++;
	endtask

	// Queue one run of samples; a fresh run opens with restart. Rare stray
	// restarts inside a run break sequences at random points.
	task automatic add_run(input int len, input run_shape_t shape, input bit fresh);
		logic signed [SAMPLE_W-1:0] v;
		logic signed [SAMPLE_W-1:0] step;
		logic                       r;
		v = SAMPLE_W'($urandom);
		step = SAMPLE_W'($urandom_range(1, 300));
		for (int i = 0; i < len; i++) begin
			case (shape)
				RUN_WIDE: v = SAMPLE_W'($urandom);
				RUN_NARROW: begin
					v = SAMPLE_W'($urandom_range(0, 8));
					v = v - 16'sd4;
				end
				RUN_FALL: v = v - step;
				RUN_RISE: v = v + step;
				default: begin
					case ($urandom_range(0, 3))
						0: v = 16'sh8000;
						1: v = 16'sh7fff;
						2: v = 16'sh0000;
						default: v = -16'sd1;
					endcase
				end
			endcase
			r = (i == 0 && fresh) || ($urandom_range(0, 199) == 0);
			push_req(v, r);
		end
	endtask

	// One random setting: write the window, then fill the budget with runs of
	// mixed shapes and lengths. Optionally carry the previous sequence over so
	// the window changes under a live sequence.
	task automatic run_phase(input logic [CFG_BITS-1:0] win, input int budget, input bit carry);
		int  left;
		int  len;
		int  span;
		int  pick;
		bit  first;
		write_window(win);
		span = (win == 0) ? 1 : (win > WIN_DEPTH) ? WIN_DEPTH : int'(win);
		left = budget;
		first = 1'b1;
		while (left > 0) begin
			pick = $urandom_range(0, 7);
			if (pick == 0)
				len = (span > 1) ? $urandom_range(1, span - 1) : 1;   // too short to fill
			else if (pick == 1)
				len = $urandom_range(150, 300);                        // wraps positions
			else
				len = $urandom_range(1, 2 * span + 8);
			if (len > left)
				len = left;
			add_run(len, run_shape_t'($urandom_range(0, 4)), !(first && carry));
			left -= len;
			first = 1'b0;
		end
	endtask

	initial begin
		logic [CFG_BITS-1:0] win_pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Window of one straight out of reset: every sample is its own maximum.
		push_req(16'sh7fff, 1'b0);
		push_req(16'sh8000, 1'b0);
		push_req(16'sh0000, 1'b0);
		push_req(-16'sd1, 1'b1);

		// Window of three: short sequence, extremes, equal values, falling tail.
		write_window(7'd3);
		push_req(16'sd100, 1'b1);
		push_req(16'sd7, 1'b0);
		push_req(16'sh8000, 1'b1);
		push_req(16'sh7fff, 1'b0);
		push_req(16'sh8000, 1'b0);
		push_req(16'sh8000, 1'b0);
		push_req(16'sh8000, 1'b0);
		push_req(16'sd5, 1'b0);
		push_req(16'sd5, 1'b0);
		push_req(16'sd5, 1'b0);
		push_req(16'sd4, 1'b0);
		push_req(16'sd3, 1'b0);
		push_req(16'sd2, 1'b0);

		// Zero acts as one; shrink under the live sequence.
		write_window(7'd0);
		push_req(16'sd9, 1'b0);
		push_req(-16'sd9, 1'b0);
		push_req(16'sd1, 1'b0);

		// Past the depth acts as the full depth; grow under the live sequence.
		write_window(7'd127);
		push_req(16'sd50, 1'b0);
		push_req(16'sd60, 1'b0);

		// Random settings: the planned extremes first, then arbitrary values.
		for (int p = 0; p < 16; p++) begin
			win_pick = (p < 10) ? win_plan[p] : 7'($urandom_range(0, 127));
			if (p == 3)
				calm = 1'b1;          // no idling on either side for this stretch
			if (p == 4)
				squeeze = 1'b1;       // receiver holds off while requests keep coming
			run_phase(win_pick, PHASE_BUDGET, 1'($urandom_range(0, 1)));
			if (p == 3) begin
				settle();
				calm = 1'b0;
			end
		end

		settle();
		$display("covered %0d samples over %0d window settings, %0d maxima checked",
			samples_taken, settings_used, maxima_checked);
		$display("including restarts, short sequences, window changes mid-sequence, long stall");
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
